// ----- rtl/ncse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncse_pkg: shared types and constants of the spline evaluator
// Widths of the fixed-point datapath, register codes and coefficient tables.
// ----------------------------------------------------------------------------
package ncse_pkg;

  localparam int DATA_W    = 16;
  localparam int NSEG      = 4;
  localparam int NKNOT     = 5;
  localparam int SEG_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Pipeline depth of the query path, output register included.
  localparam int NSTAGE = 12;

  // Datapath widths; each is sized for the worst case of 16-bit inputs.
  localparam int DX_W     = 18;  // query minus origin, and offset into segment
  localparam int DY_W     = 17;  // sample difference
  localparam int CC_W     = 25;  // scaled curvature term
  localparam int CDIFF_W  = 26;
  localparam int BB_W     = 27;
  localparam int C3_W     = 34;
  localparam int K_W      = 48;
  localparam int P1_W     = CDIFF_W + DX_W;
  localparam int G2_W     = 44;
  localparam int G2_LO_W  = 22;
  localparam int PH2_W    = G2_W - G2_LO_W + DX_W;
  localparam int PL2_W    = G2_LO_W + 1 + DX_W;
  localparam int G1_W     = 58;
  localparam int G1_LO_W  = 29;
  localparam int PH1_W    = G1_W - G1_LO_W + DX_W;
  localparam int PL1_W    = G1_LO_W + 1 + DX_W;
  localparam int N_W      = 75;
  localparam int RND_SH   = 27;
  localparam int M_W      = N_W - RND_SH;
  localparam int MP_W     = 21;
  localparam int RECIP_W  = 22;
  localparam int RECIP_SH = 26;
  localparam int PROD_W   = MP_W + RECIP_W;

  // The denominator 168 * 2^24 is 21 * 2^27: a shift, then a division by 21
  // done as a multiplication by ceil(2^26 / 21).
  localparam logic [RECIP_W-1:0] RECIP_21 = 22'd3195661;

  // 21 * 32768: bounds of the shifted numerator that still fit 16 bits.
  localparam logic signed [M_W-1:0] SAT_BOUND = 48'sd688128;

  // Half of the denominator, added before the final truncation.
  localparam logic signed [K_W-1:0] ROUND_HALF = 48'sd1409286144;

  localparam logic [DATA_W-1:0] VAL_MAX = 16'h7fff;
  localparam logic [DATA_W-1:0] VAL_MIN = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_0    = 3'd0,
    REG_SAMPLE_1    = 3'd1,
    REG_SAMPLE_2    = 3'd2,
    REG_SAMPLE_3    = 3'd3,
    REG_SAMPLE_4    = 3'd4,
    REG_KNOT_ORIGIN = 3'd5
  } cfg_reg_e;

  typedef logic [NSTAGE-1:0] pipe_en_t;

  // Per-segment polynomial coefficients, held as plain bit vectors.
  typedef struct packed {
    logic [NSEG-1:0][CDIFF_W-1:0] cdiff;
    logic [NSEG-1:0][C3_W-1:0]    c3;
    logic [NSEG-1:0][BB_W-1:0]    bb;
    logic [NSEG-1:0][K_W-1:0]     k;
  } coef_t;

endpackage

// ----- rtl/ncse_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncse_if: query and result channels of the spline evaluator
// Valid/ready streams; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ncse_query_if;
  import ncse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, output query_x, input ready);
  modport sink (input valid, input query_x, output ready);
endinterface

interface ncse_result_if;
  import ncse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     saturated;
  logic [SEG_W-1:0]         segment;

  modport source (output valid, output value, output saturated, output segment,
                  input ready);
  modport sink (input valid, input value, input saturated, input segment,
                output ready);
endinterface

// ----- rtl/natural_cubic_spline_eval_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natural_cubic_spline_eval_unit: natural cubic spline over five unit knots
// Evaluates the spline through five Q4.12 samples at Q8.8 query points.
// ----------------------------------------------------------------------------
// Usage:
// Samples and the knot origin are written through the plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i) while no query is in flight. The
// coefficient tables follow a write through the cc, dy and coef registers,
// which the pipeline hides, so a query may be transferred on the next cycle.
// Queries enter on query_ch and results leave on result_ch, both valid/ready.
// The pipeline has twelve stages, and one query per clock is sustained while
// the receiver takes results. The depth is set by the Horner evaluation,
// whose two wide products are each split into two partial products and
// summed in the next stage.
// Each stage holds its item while the stage after it is full and held, so a
// stalled receiver first lets the empty stages fill; query_ch.ready drops
// only when all twelve stages hold results. No transfer is lost or repeated.
// Reset empties the pipeline and zeroes all but the datapath registers.
// ----------------------------------------------------------------------------
module natural_cubic_spline_eval_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ncse_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ncse_pkg::DATA_W-1:0]    cfg_data_i,
  ncse_query_if.sink                     query_ch,
  ncse_result_if.source                  result_ch
);
  import ncse_pkg::*;

  logic signed [DATA_W-1:0] origin;
  coef_t                    coef;
  pipe_en_t                 pipe_en;

  ncse_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .origin_o   (origin),
    .coef_o     (coef)
  );

  ncse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (query_ch.valid),
    .in_ready_o  (query_ch.ready),
    .out_valid_o (result_ch.valid),
    .out_ready_i (result_ch.ready),
    .en_o        (pipe_en)
  );

  ncse_dpath u_dpath (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .query_x_i   (query_ch.query_x),
    .origin_i    (origin),
    .coef_i      (coef),
    .value_o     (result_ch.value),
    .saturated_o (result_ch.saturated),
    .segment_o   (result_ch.segment)
  );

endmodule

// ----- rtl/ncse_coef.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncse_coef: configuration registers and spline coefficient tables
// Holds the samples and origin, and derives the per-segment coefficients in
// two register stages.
// ----------------------------------------------------------------------------
module ncse_coef (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ncse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ncse_pkg::DATA_W-1:0]       cfg_data_i,
  output logic signed [ncse_pkg::DATA_W-1:0] origin_o,
  output ncse_pkg::coef_t                   coef_o
);
  import ncse_pkg::*;

  logic signed [DATA_W-1:0] sample_q [NKNOT];
  logic signed [DATA_W-1:0] origin_q;

  logic signed [CC_W-1:0]   cc_q [NKNOT];
  logic signed [CC_W-1:0]   cc_d [NKNOT];
  logic signed [DY_W-1:0]   dy_q [NSEG];
  logic signed [DY_W-1:0]   dy_d [NSEG];
  logic signed [CC_W-1:0]   ys [NKNOT];
  coef_t                    coef_q, coef_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NKNOT; i++) begin
        sample_q[i] <= '0;
      end
      origin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SAMPLE_0:    sample_q[0] <= cfg_data_i;
        REG_SAMPLE_1:    sample_q[1] <= cfg_data_i;
        REG_SAMPLE_2:    sample_q[2] <= cfg_data_i;
        REG_SAMPLE_3:    sample_q[3] <= cfg_data_i;
        REG_SAMPLE_4:    sample_q[4] <= cfg_data_i;
        REG_KNOT_ORIGIN: origin_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Curvature terms: 168 times the constant inverse of the 4-1 system applied
  // to the second differences, expanded directly in the samples.
  always_comb begin
    for (int i = 0; i < NKNOT; i++) begin
      ys[i] = CC_W'(sample_q[i]);
    end
    cc_d[0] = '0;
    cc_d[1] = CC_W'(45 * ys[0] - 102 * ys[1] + 72 * ys[2] - 18 * ys[3] + 3 * ys[4]);
    cc_d[2] = CC_W'(-12 * ys[0] + 72 * ys[1] - 120 * ys[2] + 72 * ys[3] - 12 * ys[4]);
    cc_d[3] = CC_W'(3 * ys[0] - 18 * ys[1] + 72 * ys[2] - 102 * ys[3] + 45 * ys[4]);
    cc_d[4] = '0;
    for (int s = 0; s < NSEG; s++) begin
      dy_d[s] = DY_W'(sample_q[s + 1]) - DY_W'(sample_q[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NKNOT; i++) begin
        cc_q[i] <= '0;
      end
      for (int s = 0; s < NSEG; s++) begin
        dy_q[s] <= '0;
      end
    end else begin
      cc_q <= cc_d;
      dy_q <= dy_d;
    end
  end

  always_comb begin
    logic signed [C3_W-1:0] c3w;
    logic signed [BB_W-1:0] dyw;
    logic signed [K_W-1:0]  yw;
    coef_d = '0;
    for (int s = 0; s < NSEG; s++) begin
      c3w = C3_W'(cc_q[s]);
      dyw = BB_W'(dy_q[s]);
      yw  = K_W'(sample_q[s]);
      coef_d.cdiff[s] = CDIFF_W'(cc_q[s + 1]) - CDIFF_W'(cc_q[s]);
      coef_d.c3[s]    = (c3w <<< 9) + (c3w <<< 8);
      coef_d.bb[s]    = (dyw <<< 7) + (dyw <<< 5) + (dyw <<< 3)
                        - BB_W'(cc_q[s + 1]) - (BB_W'(cc_q[s]) <<< 1);
      coef_d.k[s]     = (((yw <<< 7) + (yw <<< 5) + (yw <<< 3)) <<< 24) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign origin_o = origin_q;
  assign coef_o   = coef_q;

endmodule

// ----- rtl/ncse_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncse_ctrl: valid tracking and stage enables of the query pipeline
// A stage loads when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module ncse_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ncse_pkg::pipe_en_t en_o
);
  import ncse_pkg::*;

  logic [NSTAGE-1:0] vld_q, vld_d;
  logic [NSTAGE:0]   adv;

  always_comb begin
    adv[NSTAGE] = out_ready_i;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k + 1];
    end
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o        = adv[NSTAGE-1:0];
  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NSTAGE-1];

endmodule

// ----- rtl/ncse_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncse_dpath: twelve-stage evaluation datapath
// Segment search, Horner evaluation with split multiplies, rounding, division
// by 21 through a reciprocal, and saturation.
// ----------------------------------------------------------------------------
module ncse_dpath (
  input  logic                               clk_i,
  input  ncse_pkg::pipe_en_t                 en_i,
  input  logic signed [ncse_pkg::DATA_W-1:0] query_x_i,
  input  logic signed [ncse_pkg::DATA_W-1:0] origin_i,
  input  ncse_pkg::coef_t                    coef_i,
  output logic signed [ncse_pkg::DATA_W-1:0] value_o,
  output logic                               saturated_o,
  output logic [ncse_pkg::SEG_W-1:0]         segment_o
);
  import ncse_pkg::*;

  // Stage 1
  logic signed [DX_W-1:0]    dx_q;
  // Stage 2
  logic signed [DX_W-1:0]    t2_q, t_d;
  logic [SEG_W-1:0]          seg2_q, seg_d;
  // Stage 3
  logic signed [DX_W-1:0]    t3_q;
  logic [SEG_W-1:0]          seg3_q;
  logic signed [CDIFF_W-1:0] cdiff3_q;
  logic signed [C3_W-1:0]    c3_3_q;
  logic signed [BB_W-1:0]    bb3_q;
  logic signed [K_W-1:0]     k3_q;
  // Stage 4
  logic signed [P1_W-1:0]    p1_q;
  logic signed [DX_W-1:0]    t4_q;
  logic [SEG_W-1:0]          seg4_q;
  logic signed [C3_W-1:0]    c3_4_q;
  logic signed [BB_W-1:0]    bb4_q;
  logic signed [K_W-1:0]     k4_q;
  // Stage 5
  logic signed [G2_W-1:0]    g2_q;
  logic signed [DX_W-1:0]    t5_q;
  logic [SEG_W-1:0]          seg5_q;
  logic signed [BB_W-1:0]    bb5_q;
  logic signed [K_W-1:0]     k5_q;
  // Stage 6
  logic signed [G2_W-G2_LO_W-1:0] g2_hi;
  logic signed [G2_LO_W:0]        g2_lo;
  logic signed [PH2_W-1:0]   ph2_q;
  logic signed [PL2_W-1:0]   pl2_q;
  logic signed [DX_W-1:0]    t6_q;
  logic [SEG_W-1:0]          seg6_q;
  logic signed [BB_W-1:0]    bb6_q;
  logic signed [K_W-1:0]     k6_q;
  // Stage 7
  logic signed [G1_W-1:0]    g1_q;
  logic signed [DX_W-1:0]    t7_q;
  logic [SEG_W-1:0]          seg7_q;
  logic signed [K_W-1:0]     k7_q;
  // Stage 8
  logic signed [G1_W-G1_LO_W-1:0] g1_hi;
  logic signed [G1_LO_W:0]        g1_lo;
  logic signed [PH1_W-1:0]   ph1_q;
  logic signed [PL1_W-1:0]   pl1_q;
  logic [SEG_W-1:0]          seg8_q;
  logic signed [K_W-1:0]     k8_q;
  // Stage 9
  logic signed [N_W-1:0]     n_q;
  logic [SEG_W-1:0]          seg9_q;
  // Stage 10
  logic signed [M_W-1:0]     m;
  logic [MP_W-1:0]           mp_q;
  logic                      sat_hi10_q, sat_lo10_q;
  logic [SEG_W-1:0]          seg10_q;
  // Stage 11
  logic [PROD_W-1:0]         prod_q;
  logic                      sat_hi11_q, sat_lo11_q;
  logic [SEG_W-1:0]          seg11_q;
  // Stage 12 (output register)
  logic [DATA_W-1:0]         quo;
  logic signed [DATA_W-1:0]  value_q;
  logic                      sat_q;
  logic [SEG_W-1:0]          seg_q;

  // The segment is the last of knots 0-3 strictly below the query, else knot 0.
  always_comb begin
    if (dx_q > DX_W'(768)) begin
      seg_d = 2'd3;
    end else if (dx_q > DX_W'(512)) begin
      seg_d = 2'd2;
    end else if (dx_q > DX_W'(256)) begin
      seg_d = 2'd1;
    end else begin
      seg_d = 2'd0;
    end
    t_d = dx_q - $signed({{(DX_W - SEG_W - 8){1'b0}}, seg_d, 8'b0});
  end

  assign g2_hi = g2_q[G2_W-1:G2_LO_W];
  assign g2_lo = {1'b0, g2_q[G2_LO_W-1:0]};
  assign g1_hi = g1_q[G1_W-1:G1_LO_W];
  assign g1_lo = {1'b0, g1_q[G1_LO_W-1:0]};
  assign m     = n_q[N_W-1:RND_SH];
  assign quo   = prod_q[RECIP_SH +: DATA_W];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q <= DX_W'(query_x_i) - DX_W'(origin_i);
    end
    if (en_i[1]) begin
      seg2_q <= seg_d;
      t2_q   <= t_d;
    end
    if (en_i[2]) begin
      seg3_q   <= seg2_q;
      t3_q     <= t2_q;
      cdiff3_q <= $signed(coef_i.cdiff[seg2_q]);
      c3_3_q   <= $signed(coef_i.c3[seg2_q]);
      bb3_q    <= $signed(coef_i.bb[seg2_q]);
      k3_q     <= $signed(coef_i.k[seg2_q]);
    end
    if (en_i[3]) begin
      p1_q   <= cdiff3_q * t3_q;
      t4_q   <= t3_q;
      seg4_q <= seg3_q;
      c3_4_q <= c3_3_q;
      bb4_q  <= bb3_q;
      k4_q   <= k3_q;
    end
    if (en_i[4]) begin
      g2_q   <= G2_W'(p1_q) + G2_W'(c3_4_q);
      t5_q   <= t4_q;
      seg5_q <= seg4_q;
      bb5_q  <= bb4_q;
      k5_q   <= k4_q;
    end
    if (en_i[5]) begin
      ph2_q  <= g2_hi * t5_q;
      pl2_q  <= g2_lo * t5_q;
      t6_q   <= t5_q;
      seg6_q <= seg5_q;
      bb6_q  <= bb5_q;
      k6_q   <= k5_q;
    end
    if (en_i[6]) begin
      g1_q   <= (G1_W'(ph2_q) <<< G2_LO_W) + G1_W'(pl2_q) + (G1_W'(bb6_q) <<< 16);
      t7_q   <= t6_q;
      seg7_q <= seg6_q;
      k7_q   <= k6_q;
    end
    if (en_i[7]) begin
      ph1_q  <= g1_hi * t7_q;
      pl1_q  <= g1_lo * t7_q;
      seg8_q <= seg7_q;
      k8_q   <= k7_q;
    end
    if (en_i[8]) begin
      n_q    <= (N_W'(ph1_q) <<< G1_LO_W) + N_W'(pl1_q) + N_W'(k8_q);
      seg9_q <= seg8_q;
    end
    if (en_i[9]) begin
      // Offset the numerator so the in-range window starts at zero.
      mp_q       <= MP_W'(m + SAT_BOUND);
      sat_hi10_q <= (m >= SAT_BOUND);
      sat_lo10_q <= (m < -SAT_BOUND);
      seg10_q    <= seg9_q;
    end
    if (en_i[10]) begin
      prod_q     <= PROD_W'(mp_q) * PROD_W'(RECIP_21);
      sat_hi11_q <= sat_hi10_q;
      sat_lo11_q <= sat_lo10_q;
      seg11_q    <= seg10_q;
    end
    if (en_i[11]) begin
      if (sat_hi11_q) begin
        value_q <= VAL_MAX;
      end else if (sat_lo11_q) begin
        value_q <= VAL_MIN;
      end else begin
        // Removing the offset of 32768 flips the top bit of the quotient.
        value_q <= {~quo[DATA_W-1], quo[DATA_W-2:0]};
      end
      sat_q <= sat_hi11_q | sat_lo11_q;
      seg_q <= seg11_q;
    end
  end

  assign value_o     = value_q;
  assign saturated_o = sat_q;
  assign segment_o   = seg_q;

endmodule

// ----- rtl/ncse_sva.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncse_sva: port-level checks of the spline evaluator
// Watches the result channel and reset; bound to the top level.
// ----------------------------------------------------------------------------
module ncse_sva (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [ncse_pkg::DATA_W-1:0]    res_value_i,
  input logic                           res_sat_i,
  input logic [ncse_pkg::SEG_W-1:0]     res_seg_i
);
  import ncse_pkg::*;

  // A clipped result carries one of the two range limits.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_sat_i |-> res_value_i == VAL_MAX || res_value_i == VAL_MIN)
    else $error("saturated result not at a range limit");

  // The pipeline is empty while reset is applied.
  a_empty_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped without a transfer");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable({res_value_i, res_sat_i, res_seg_i}))
    else $error("result payload changed while stalled");

endmodule

bind natural_cubic_spline_eval_unit ncse_sva u_ncse_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_ch.valid),
  .res_ready_i (result_ch.ready),
  .res_value_i (result_ch.value),
  .res_sat_i   (result_ch.saturated),
  .res_seg_i   (result_ch.segment)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the natural cubic spline evaluator
// Loads sample sets and knot origins through the write port, streams queries
// and compares every result transfer against a bit-exact integer prediction
// of the spline, under several patterns of idle senders and stalled receivers.
// ----------------------------------------------------------------------------
module testbench;
  import ncse_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 80;
  localparam int BLOCKS         = 16;
  localparam int BLOCK_QUERIES  = 58;
  localparam int PRESSURE_BLOCK = 8;

  // Register indexes that map to nothing; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

  // Denominator of the exact polynomial value: 168 * 2^24.
  localparam longint SPLINE_SCALE = 64'sd2818572288;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              saturated;
    logic [SEG_W-1:0]  segment;
  } spline_result_t;

  typedef logic [DATA_W-1:0] cfg_set_t [6];

  class spline_scoreboard;
    longint         sample_q [NKNOT];
    longint         origin_q;
    spline_result_t due_values [$];
    int             errors;

    function new();
      for (int k = 0; k < NKNOT; k++) sample_q[k] = 0;
      origin_q = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_SAMPLE_0, REG_SAMPLE_1, REG_SAMPLE_2, REG_SAMPLE_3, REG_SAMPLE_4: begin
          sample_q[idx] = longint'($signed(data));
        end
        REG_KNOT_ORIGIN: begin
          origin_q = longint'($signed(data));
        end
        default: ;
      endcase
    endfunction

    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
    endfunction

    function int pending();
      return due_values.size();
    endfunction

    function void note_query(logic [DATA_W-1:0] x_bits);
      longint         x, t, cdiff, bb, g2, g1, qh, rh, v;
      longint         dd [3];
      longint         cc [NKNOT];
      int             seg;
      spline_result_t res;
      x = longint'($signed(x_bits));
      for (int k = 0; k < 3; k++)
        dd[k] = sample_q[k + 2] - 2 * sample_q[k + 1] + sample_q[k];
      // Curvature terms from the constant inverse of the 4-1 system, times 168.
      cc[0] = 0;
      cc[1] = 3 * (15 * dd[0] - 4 * dd[1] + dd[2]);
      cc[2] = 3 * (-4 * dd[0] + 16 * dd[1] - 4 * dd[2]);
      cc[3] = 3 * (dd[0] - 4 * dd[1] + 15 * dd[2]);
      cc[4] = 0;
      seg = 0;
      for (int k = 1; k < NSEG; k++)
        if (origin_q + 256 * longint'(k) < x) seg = k;
      t     = x - (origin_q + 256 * longint'(seg));
      cdiff = cc[seg + 1] - cc[seg];
      bb    = 168 * (sample_q[seg + 1] - sample_q[seg]) - (cc[seg + 1] + 2 * cc[seg]);
      g2    = cdiff * t + 3 * cc[seg] * 256;
      g1    = g2 * t + bb * 65536;
      // The last Horner step is split so that no product leaves 64 bits.
      qh = floor_quot(g1, SPLINE_SCALE);
      rh = g1 - qh * SPLINE_SCALE;
      v  = qh * t + floor_quot(rh * t + 168 * sample_q[seg] * 16777216
                               + SPLINE_SCALE / 2, SPLINE_SCALE);
      res.saturated = 1'b0;
      if (v > 32767) begin
        v = 32767;
        res.saturated = 1'b1;
      end else if (v < -32768) begin
        v = -32768;
        res.saturated = 1'b1;
      end
      res.value   = v[DATA_W-1:0];
      res.segment = SEG_W'(seg);
      due_values.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] value, logic saturated,
                               logic [SEG_W-1:0] segment);
      spline_result_t due;
      if (due_values.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no query pending: value %h saturated %b segment %0d",
                 $time, value, saturated, segment);
        return;
      end
      due = due_values.pop_front();
      if (due.value !== value) begin
        errors++;
        $display("%0t: value mismatch: expected %h, actual %h", $time, due.value, value);
      end
      if (due.saturated !== saturated) begin
        errors++;
        $display("%0t: saturated mismatch: expected %b, actual %b", $time, due.saturated,
                 saturated);
      end
      if (due.segment !== segment) begin
        errors++;
        $display("%0t: segment mismatch: expected %0d, actual %0d", $time, due.segment,
                 segment);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;

  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles = 0;

  spline_scoreboard sb = new();

  ncse_query_if  query_ch ();
  ncse_result_if result_ch ();

  natural_cubic_spline_eval_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .query_ch   (query_ch),
    .result_ch  (result_ch)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Offer one query; returns at the edge of its transfer.
  task automatic send_query(input logic [DATA_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid   <= 1'b1;
    query_ch.query_x <= x;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
  endtask

  // Write all six registers back to back, optionally followed by the two
  // unmapped indexes.
  task automatic load_config(input cfg_set_t vals, input bit stray);
    for (int i = REG_SAMPLE_0; i <= REG_KNOT_ORIGIN; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    if (stray) begin
      cfg_idx  <= UNMAPPED_IDX_LO;
      cfg_data <= 16'($urandom);
      @(posedge clk);
      cfg_idx  <= UNMAPPED_IDX_HI;
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait until every pending result has been transferred.
  task automatic drain_results();
    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    bit hold_seen;
    hold_seen       = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_data);
      if (query_ch.valid && query_ch.ready) sb.note_query(query_ch.query_x);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.value, result_ch.saturated, result_ch.segment);
    end
  end

  always @(posedge clk) begin
    if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_set_t          vals;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] org;
    int                mode;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    query_ch.valid   = 1'b0;
    query_ch.query_x = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_req         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers straight out of reset: all zero.
    send_query(16'h0000);
    send_query(16'h7fff);
    send_query(16'h8000);
    drain_results();

    // A straight ramp: half-step queries land exactly on rounding ties, and
    // queries on a knot belong to the segment below it.
    load_config('{16'd0, 16'd128, 16'd256, 16'd384, 16'd512, 16'd0}, 1'b0);
    send_query(16'h0001);
    send_query(16'hffff);
    send_query(16'd256);
    send_query(16'd257);
    send_query(16'd1024);
    send_query(16'd1025);
    drain_results();

    // Alternating extremes at the lowest origin, with writes to the unmapped
    // indexes that must leave the set untouched.
    load_config('{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 16'h8000}, 1'b1);
    send_query(16'h8000);
    send_query(16'h8001);
    send_query(16'h8100);
    send_query(16'h8101);
    send_query(16'h8300);
    send_query(16'h8400);
    send_query(16'h7fff);
    send_query(16'h0000);
    drain_results();

    // Highest origin: every query extrapolates the first segment.
    load_config('{VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 16'h7fff}, 1'b0);
    send_query(16'h8000);
    send_query(16'h7fff);
    send_query(16'h0000);
    drain_results();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      mode = (blk / 2) % 4;
      case (mode)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 88;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct    <= 23;
        end
      endcase

      for (int k = REG_SAMPLE_0; k <= REG_SAMPLE_4; k++) begin
        case ($urandom_range(3))
          0: vals[k] = 16'($urandom);
          1: vals[k] = 16'($urandom_range(8191)) - 16'd4096;
          2: vals[k] = $urandom_range(1) ? VAL_MAX : VAL_MIN;
          default: begin
            // A smooth walk keeps the spline mostly inside the range.
            if (k == REG_SAMPLE_0) vals[k] = 16'($urandom_range(4095));
            else vals[k] = vals[k - 1] + 16'($urandom_range(1023)) - 16'd512;
          end
        endcase
      end
      case ($urandom_range(3))
        0: vals[REG_KNOT_ORIGIN] = 16'($urandom_range(2047)) - 16'd1024;
        1: vals[REG_KNOT_ORIGIN] = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: vals[REG_KNOT_ORIGIN] = 16'($urandom);
      endcase
      org = vals[REG_KNOT_ORIGIN];
      load_config(vals, $urandom_range(3) == 0);

      // Long receiver hold-off while queries keep coming: the pipeline fills
      // and the query channel has to stall.
      if (blk == PRESSURE_BLOCK) hold_req <= ~hold_req;

      for (int i = 0; i < BLOCK_QUERIES; i++) begin
        case ($urandom_range(9))
          0, 1: x = 16'($urandom);
          2, 3: x = org + 16'(256 * $urandom_range(4)) + 16'($urandom_range(2)) - 16'd1;
          default: x = org + 16'($urandom_range(2047)) - 16'd512;
        endcase
        send_query(x);
      end
      drain_results();
    end

    repeat (NSTAGE + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
